FILE: design/cip_pkg.sv
package cip_pkg;

  localparam int ROWS     = 8;
  localparam int ROW_W    = $clog2(ROWS);
  localparam int PIX_W    = 8;
  localparam int LINE_W   = ROWS * PIX_W;

  localparam logic [ROW_W-1:0] ROW_LAST = ROW_W'(ROWS - 1);

  localparam logic [1:0] MODE_DC   = 2'd0;
  localparam logic [1:0] MODE_VERT = 2'd1;
  localparam logic [1:0] MODE_HORZ = 2'd2;
  localparam logic [1:0] MODE_TM   = 2'd3;

  localparam logic [PIX_W-1:0] DC_NONE = 8'd128;
  localparam logic [PIX_W-1:0] PIX_MAX = 8'd255;

  // Held block request; DC values are resolved when the request is taken
  typedef struct packed {
    logic [1:0]        mode;
    logic [LINE_W-1:0] u_above;
    logic [LINE_W-1:0] v_above;
    logic [LINE_W-1:0] u_left;
    logic [LINE_W-1:0] v_left;
    logic [PIX_W-1:0]  u_corner;
    logic [PIX_W-1:0]  v_corner;
    logic [PIX_W-1:0]  u_dc;
    logic [PIX_W-1:0]  v_dc;
  } req_t;

  function automatic logic [LINE_W-1:0] splat(input logic [PIX_W-1:0] px);
    logic [LINE_W-1:0] r;
    for (int c = 0; c < ROWS; c++) begin
      r[c*PIX_W +: PIX_W] = px;
    end
    return r;
  endfunction

endpackage

FILE: design/cip_dc.sv
module cip_dc
  import cip_pkg::*;
(
  input  logic [LINE_W-1:0] above,
  input  logic [LINE_W-1:0] left,
  input  logic              up_ok,
  input  logic              left_ok,
  output logic [PIX_W-1:0]  dc
);

  localparam int SUM_W = PIX_W + ROW_W;

  logic [SUM_W-1:0] sum_above;
  logic [SUM_W-1:0] sum_left;
  logic [SUM_W:0]   sum_both;
  logic [SUM_W-1:0] avg_one;
  logic [SUM_W:0]   avg_two;

  always_comb begin
    sum_above = '0;
    sum_left  = '0;
    for (int i = 0; i < ROWS; i++) begin
      sum_above = sum_above + SUM_W'(above[i*PIX_W +: PIX_W]);
      sum_left  = sum_left  + SUM_W'(left[i*PIX_W +: PIX_W]);
    end
  end

  assign sum_both = {1'b0, sum_above} + {1'b0, sum_left} + (SUM_W+1)'(ROWS);
  assign avg_one  = (up_ok ? sum_above : sum_left) + SUM_W'(ROWS / 2);
  assign avg_two  = sum_both >> (ROW_W + 1);

  always_comb begin
    if (up_ok && left_ok) begin
      dc = avg_two[PIX_W-1:0];
    end else if (up_ok || left_ok) begin
      dc = avg_one[SUM_W-1:ROW_W];
    end else begin
      dc = DC_NONE;
    end
  end

endmodule

FILE: design/cip_row.sv
module cip_row
  import cip_pkg::*;
(
  input  req_t              req,
  input  logic [ROW_W-1:0]  row,
  output logic [LINE_W-1:0] u_row,
  output logic [LINE_W-1:0] v_row
);

  function automatic logic [LINE_W-1:0] tm_line(input logic [LINE_W-1:0] above,
                                                input logic [PIX_W-1:0]  left_px,
                                                input logic [PIX_W-1:0]  corner);
    logic [LINE_W-1:0] r;
    logic signed [PIX_W+1:0] p;
    for (int c = 0; c < ROWS; c++) begin
      p = $signed({2'b00, left_px}) + $signed({2'b00, above[c*PIX_W +: PIX_W]})
          - $signed({2'b00, corner});
      if (p < 0) begin
        r[c*PIX_W +: PIX_W] = '0;
      end else if (p > $signed({2'b00, PIX_MAX})) begin
        r[c*PIX_W +: PIX_W] = PIX_MAX;
      end else begin
        r[c*PIX_W +: PIX_W] = p[PIX_W-1:0];
      end
    end
    return r;
  endfunction

  logic [PIX_W-1:0] u_left_px;
  logic [PIX_W-1:0] v_left_px;

  assign u_left_px = req.u_left[row*PIX_W +: PIX_W];
  assign v_left_px = req.v_left[row*PIX_W +: PIX_W];

  always_comb begin
    unique case (req.mode)
      MODE_DC: begin
        u_row = splat(req.u_dc);
        v_row = splat(req.v_dc);
      end
      MODE_VERT: begin
        u_row = req.u_above;
        v_row = req.v_above;
      end
      MODE_HORZ: begin
        u_row = splat(u_left_px);
        v_row = splat(v_left_px);
      end
      default: begin
        u_row = tm_line(req.u_above, u_left_px, req.u_corner);
        v_row = tm_line(req.v_above, v_left_px, req.v_corner);
      end
    endcase
  end

endmodule

FILE: design/chroma_intra_predictor_8x8_unit.sv
// 8x8 chroma intra predictor (DC, vertical, horizontal, TrueMotion). A block
// request is taken in one transaction and yields eight row transactions, row 0
// first, each carrying eight U and eight V predicted bytes; last_row marks row
// 7. Rows leave at one per cycle while the output is not stalled, and a new
// request is taken in the same cycle its last row moves into the output
// register, so blocks follow back to back. The DC averages are formed as the
// request is taken; each row is built from the held request between the
// request register and the output register.
module chroma_intra_predictor_8x8_unit
  import cip_pkg::*;
(
  input  logic              clk,
  input  logic              rst,
  input  logic              in_valid,
  output logic              in_stall,
  input  logic [1:0]        mode,
  input  logic              above_present,
  input  logic              left_present,
  input  logic [LINE_W-1:0] u_above,
  input  logic [LINE_W-1:0] v_above,
  input  logic [LINE_W-1:0] u_left,
  input  logic [LINE_W-1:0] v_left,
  input  logic [PIX_W-1:0]  u_corner,
  input  logic [PIX_W-1:0]  v_corner,
  output logic              out_valid,
  input  logic              out_stall,
  output logic [ROW_W-1:0]  row_number,
  output logic [LINE_W-1:0] u_row,
  output logic [LINE_W-1:0] v_row,
  output logic              last_row
);

  req_t              req;
  logic              req_valid;
  logic [ROW_W-1:0]  row_counter;
  logic [PIX_W-1:0]  u_dc;
  logic [PIX_W-1:0]  v_dc;
  logic [LINE_W-1:0] u_line;
  logic [LINE_W-1:0] v_line;
  logic              in_take;
  logic              out_load;
  logic              req_done;

  cip_dc u_dc_unit (
    .above   (u_above),
    .left    (u_left),
    .up_ok   (above_present),
    .left_ok (left_present),
    .dc      (u_dc)
  );

  cip_dc v_dc_unit (
    .above   (v_above),
    .left    (v_left),
    .up_ok   (above_present),
    .left_ok (left_present),
    .dc      (v_dc)
  );

  cip_row row_unit (
    .req   (req),
    .row   (row_counter),
    .u_row (u_line),
    .v_row (v_line)
  );

  assign out_load = req_valid && (!out_valid || !out_stall);
  assign req_done = out_load && (row_counter == ROW_LAST);
  assign in_stall = req_valid && !req_done;
  assign in_take  = in_valid && !in_stall;

  always_ff @(posedge clk) begin
    if (rst) begin
      req_valid   <= 1'b0;
      row_counter <= '0;
    end else if (in_take) begin
      req_valid   <= 1'b1;
      row_counter <= '0;
    end else if (out_load) begin
      // drop the request once its last row has left
      req_valid   <= !req_done;
      row_counter <= row_counter + ROW_W'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (in_take) begin
      req.mode     <= mode;
      req.u_above  <= u_above;
      req.v_above  <= v_above;
      req.u_left   <= u_left;
      req.v_left   <= v_left;
      req.u_corner <= u_corner;
      req.v_corner <= v_corner;
      req.u_dc     <= u_dc;
      req.v_dc     <= v_dc;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (out_load) begin
      out_valid <= 1'b1;
    end else if (!out_stall) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (out_load) begin
      row_number <= row_counter;
      u_row      <= u_line;
      v_row      <= v_line;
      last_row   <= (row_counter == ROW_LAST);
    end
  end

  a_take_restarts_rows: assert property (@(posedge clk) disable iff (rst)
    in_take |=> (req_valid && row_counter == '0))
    else $error("new request did not restart at row 0");

  a_take_only_after_last: assert property (@(posedge clk) disable iff (rst)
    (req_valid && !in_stall) |-> (out_load && row_counter == ROW_LAST))
    else $error("request replaced before its last row left");

  a_last_flag: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> (last_row == (row_number == ROW_LAST)))
    else $error("last_row does not match row_number");

  a_rows_follow: assert property (@(posedge clk) disable iff (rst)
    (out_valid && !out_stall && !last_row) |=>
      (out_valid && row_number == ROW_W'($past(row_number) + ROW_W'(1))))
    else $error("row sequence broken inside a block");

endmodule

FILE: sim/tb_top.sv
module tb_top;
  import cip_pkg::*;

  localparam int RANDOM_REQS = 443;
  localparam int STALL_LIMIT = 1000;
  localparam int DRAIN_CYCLES = 16;

  typedef struct packed {
    logic [1:0]        mode;
    logic              above_present;
    logic              left_present;
    logic [LINE_W-1:0] u_above;
    logic [LINE_W-1:0] v_above;
    logic [LINE_W-1:0] u_left;
    logic [LINE_W-1:0] v_left;
    logic [PIX_W-1:0]  u_corner;
    logic [PIX_W-1:0]  v_corner;
  } block_req_t;

  typedef struct packed {
    logic [ROW_W-1:0]  row_number;
    logic [LINE_W-1:0] u_row;
    logic [LINE_W-1:0] v_row;
    logic              last_row;
  } pred_row_t;

  logic              clk = 1'b0;
  logic              rst = 1'b1;
  logic              in_valid = 1'b0;
  logic              in_stall;
  logic              out_valid;
  logic              out_stall = 1'b0;
  logic [ROW_W-1:0]  row_number;
  logic [LINE_W-1:0] u_row;
  logic [LINE_W-1:0] v_row;
  logic              last_row;
  block_req_t        drv_req = '0;

  block_req_t pending_reqs[$];
  pred_row_t  expected_rows[$];
  int         total_reqs = 0;
  int         directed_reqs = 0;
  int         reqs_taken = 0;
  int         rows_checked = 0;
  int         errors = 0;
  int         reset_count = 0;
  int         idle_cycles = 0;
  int         mode_hits[4] = '{0, 0, 0, 0};
  logic       req_taken = 1'b0;

  chroma_intra_predictor_8x8_unit u_dut (
    .clk            (clk),
    .rst            (rst),
    .in_valid       (in_valid),
    .in_stall       (in_stall),
    .mode           (drv_req.mode),
    .above_present  (drv_req.above_present),
    .left_present   (drv_req.left_present),
    .u_above        (drv_req.u_above),
    .v_above        (drv_req.v_above),
    .u_left         (drv_req.u_left),
    .v_left         (drv_req.v_left),
    .u_corner       (drv_req.u_corner),
    .v_corner       (drv_req.v_corner),
    .out_valid      (out_valid),
    .out_stall      (out_stall),
    .row_number     (row_number),
    .u_row          (u_row),
    .v_row          (v_row),
    .last_row       (last_row)
  );

  initial begin
    forever #1 clk = ~clk;
  end

  function automatic logic [PIX_W-1:0] dc_level(input logic [LINE_W-1:0] above,
                                                 input logic [LINE_W-1:0] left,
                                                 input logic up, input logic lf);
    int sum;
    int shift;
    sum = 0;
    shift = 2;
    if (!up && !lf) return DC_NONE;
    for (int c = 0; c < ROWS; c++) begin
      if (up) sum += above[c*PIX_W +: PIX_W];
      if (lf) sum += left[c*PIX_W +: PIX_W];
    end
    if (up) shift++;
    if (lf) shift++;
    return PIX_W'((sum + (1 << (shift - 1))) >> shift);
  endfunction

  // left + above - corner per column, clamped to the pixel range
  function automatic logic [LINE_W-1:0] tm_line(input logic [LINE_W-1:0] above,
                                                input logic [PIX_W-1:0] left_px,
                                                input logic [PIX_W-1:0] corner);
    logic [LINE_W-1:0] line;
    int l;
    int a;
    int k;
    int p;
    l = left_px;
    k = corner;
    for (int c = 0; c < ROWS; c++) begin
      a = above[c*PIX_W +: PIX_W];
      p = l + a - k;
      if (p < 0) p = 0;
      if (p > 255) p = 255;
      line[c*PIX_W +: PIX_W] = PIX_W'(p);
    end
    return line;
  endfunction

  task automatic predict_block(input block_req_t r);
    logic [PIX_W-1:0]  udc;
    logic [PIX_W-1:0]  vdc;
    logic [LINE_W-1:0] ur;
    logic [LINE_W-1:0] vr;
    udc = dc_level(r.u_above, r.u_left, r.above_present, r.left_present);
    vdc = dc_level(r.v_above, r.v_left, r.above_present, r.left_present);
    mode_hits[r.mode]++;
    for (int row = 0; row < ROWS; row++) begin
      case (r.mode)
        MODE_DC: begin
          ur = {ROWS{udc}};
          vr = {ROWS{vdc}};
        end
        MODE_VERT: begin
          ur = r.u_above;
          vr = r.v_above;
        end
        MODE_HORZ: begin
          ur = {ROWS{r.u_left[row*PIX_W +: PIX_W]}};
          vr = {ROWS{r.v_left[row*PIX_W +: PIX_W]}};
        end
        default: begin
          ur = tm_line(r.u_above, r.u_left[row*PIX_W +: PIX_W], r.u_corner);
          vr = tm_line(r.v_above, r.v_left[row*PIX_W +: PIX_W], r.v_corner);
        end
      endcase
      expected_rows.push_back('{ROW_W'(row), ur, vr, row == ROWS - 1});
    end
  endtask

  function automatic int field_ok(input string name, input logic [LINE_W-1:0] exp_val,
                                  input logic [LINE_W-1:0] act_val);
    if (exp_val === act_val) return 1;
    $display("%0t mismatch %s: expected %h actual %h", $time, name, exp_val, act_val);
    return 0;
  endfunction

  function automatic block_req_t make_req(input logic [1:0] m, input logic up,
                                          input logic lf,
                                          input logic [LINE_W-1:0] ua,
                                          input logic [LINE_W-1:0] va,
                                          input logic [LINE_W-1:0] ul,
                                          input logic [LINE_W-1:0] vl,
                                          input logic [PIX_W-1:0] uc,
                                          input logic [PIX_W-1:0] vc);
    return '{m, up, lf, ua, va, ul, vl, uc, vc};
  endfunction

  // Bias toward all-zero and all-ones lines to hit the clamps and DC extremes
  function automatic logic [LINE_W-1:0] rand_line();
    case ($urandom_range(7))
      0: return '0;
      1: return '1;
      2: return {ROWS{PIX_W'($urandom)}};
      default: return {$urandom, $urandom};
    endcase
  endfunction

  function automatic logic [PIX_W-1:0] rand_pix();
    case ($urandom_range(5))
      0: return '0;
      1: return PIX_MAX;
      default: return PIX_W'($urandom);
    endcase
  endfunction

  initial begin
    pending_reqs.push_back(make_req(MODE_DC, 1'b0, 1'b0, rand_line(), rand_line(),
                                    rand_line(), rand_line(), rand_pix(), rand_pix()));
    pending_reqs.push_back(make_req(MODE_DC, 1'b1, 1'b0, '1, '0, rand_line(), rand_line(),
                                    8'h00, 8'hff));
    pending_reqs.push_back(make_req(MODE_DC, 1'b0, 1'b1, rand_line(), rand_line(), '1, '0,
                                    8'hff, 8'h00));
    pending_reqs.push_back(make_req(MODE_DC, 1'b1, 1'b1, '1, '1, '1, '1, 8'h00, 8'h00));
    pending_reqs.push_back(make_req(MODE_DC, 1'b1, 1'b1, '0, '0, '0, '0, 8'hff, 8'hff));
    pending_reqs.push_back(make_req(MODE_DC, 1'b1, 1'b1, {$urandom, $urandom},
                                    {$urandom, $urandom}, {$urandom, $urandom},
                                    {$urandom, $urandom}, rand_pix(), rand_pix()));
    // rounding edges: sums just at and just below a half step
    pending_reqs.push_back(make_req(MODE_DC, 1'b1, 1'b0, 64'h4, 64'h3, '1, '1, 8'h0, 8'h0));
    pending_reqs.push_back(make_req(MODE_DC, 1'b1, 1'b1, 64'h8, 64'h7, '0, '0, 8'h0, 8'h0));
    pending_reqs.push_back(make_req(MODE_VERT, 1'b0, 1'b0, '1, '0, rand_line(), rand_line(),
                                    rand_pix(), rand_pix()));
    pending_reqs.push_back(make_req(MODE_VERT, 1'b1, 1'b1, {$urandom, $urandom},
                                    {$urandom, $urandom}, '1, '0, 8'hff, 8'h00));
    pending_reqs.push_back(make_req(MODE_HORZ, 1'b0, 1'b0, rand_line(), rand_line(),
                                    64'hff7f_fe80_0302_0100, 64'h0001_0203_80fe_7fff,
                                    rand_pix(), rand_pix()));
    pending_reqs.push_back(make_req(MODE_HORZ, 1'b1, 1'b1, '0, '1, {$urandom, $urandom},
                                    {$urandom, $urandom}, 8'h00, 8'hff));
    pending_reqs.push_back(make_req(MODE_TM, 1'b1, 1'b1, '1, '1, '1, '1, 8'h00, 8'h00));
    pending_reqs.push_back(make_req(MODE_TM, 1'b1, 1'b1, '0, '0, '0, '0, 8'hff, 8'hff));
    pending_reqs.push_back(make_req(MODE_TM, 1'b0, 1'b0, '0, '1, '1, '0, 8'h00, 8'hff));
    pending_reqs.push_back(make_req(MODE_TM, 1'b0, 1'b0, {$urandom, $urandom},
                                    {$urandom, $urandom}, {$urandom, $urandom},
                                    {$urandom, $urandom}, rand_pix(), rand_pix()));
    pending_reqs.push_back(make_req(MODE_TM, 1'b1, 1'b1, {$urandom, $urandom},
                                    {$urandom, $urandom}, {$urandom, $urandom},
                                    {$urandom, $urandom}, 8'h80, 8'h7f));
    directed_reqs = pending_reqs.size();
    for (int i = 0; i < RANDOM_REQS; i++) begin
      pending_reqs.push_back(make_req(2'($urandom_range(3)), 1'($urandom), 1'($urandom),
                                      rand_line(), rand_line(), rand_line(), rand_line(),
                                      rand_pix(), rand_pix()));
    end
    total_reqs = pending_reqs.size();

    wait (reqs_taken == total_reqs && rows_checked == total_reqs * ROWS);
    repeat (DRAIN_CYCLES) @(posedge clk);
    $display("Ran %0d block requests (%0d directed), %0d rows checked", total_reqs,
             directed_reqs, rows_checked);
    $display("Modes DC/V/H/TM: %0d/%0d/%0d/%0d, %0d errors", mode_hits[0], mode_hits[1],
             mode_hits[2], mode_hits[3], errors);
    if (errors == 0) begin
      $display("PASS chroma_intra_predictor_8x8_unit");
    end else begin
      $display("FAIL chroma_intra_predictor_8x8_unit");
    end
    $finish;
  end

  // Driver: hold reset, then present requests and toggle the output stall
  always @(negedge clk) begin
    int phase;
    int send_idle;
    int recv_idle;
    phase = (total_reqs == 0) ? 2 : (reqs_taken * 3) / total_reqs;
    send_idle = (phase == 0) ? 20 : (phase == 1) ? 69 : 0;
    recv_idle = (phase == 0) ? 69 : (phase == 1) ? 20 : 0;
    if (reset_count != 6) begin
      reset_count <= reset_count + 1;
      if (reset_count == 5) rst <= 1'b0;
    end else begin
      out_stall <= ($urandom_range(99) < recv_idle);
      // hold a stalled transaction; otherwise advance or idle
      if (!in_valid || req_taken) begin
        if (pending_reqs.size() != 0 && $urandom_range(99) >= send_idle) begin
          drv_req <= pending_reqs.pop_front();
          in_valid <= 1'b1;
        end else begin
          in_valid <= 1'b0;
        end
      end
    end
  end

  // Monitor: predict on each accepted request, check each accepted row
  always @(posedge clk) begin
    pred_row_t exp_row;
    int ok;
    if (!rst) begin
      req_taken <= in_valid && !in_stall;
      if (in_valid && !in_stall) begin
        predict_block(drv_req);
        reqs_taken <= reqs_taken + 1;
      end
      if (out_valid && !out_stall) begin
        if (expected_rows.size() == 0) begin
          $display("%0t unexpected row: row_number %0d u_row %h v_row %h", $time,
                   row_number, u_row, v_row);
          errors <= errors + 1;
        end else begin
          exp_row = expected_rows.pop_front();
          ok = field_ok("row_number", exp_row.row_number, row_number)
             & field_ok("u_row", exp_row.u_row, u_row)
             & field_ok("v_row", exp_row.v_row, v_row)
             & field_ok("last_row", exp_row.last_row, last_row);
          if (!ok) errors <= errors + 1;
          rows_checked <= rows_checked + 1;
        end
      end
    end
  end

  always @(posedge clk) begin
    if (rst || (in_valid && !in_stall) || (out_valid && !out_stall)) begin
      idle_cycles <= 0;
    end else if (idle_cycles == STALL_LIMIT) begin
      $display("%0t timeout: no transaction for %0d cycles", $time, STALL_LIMIT);
      $display("FAIL chroma_intra_predictor_8x8_unit");
      $finish;
    end else begin
      idle_cycles <= idle_cycles + 1;
    end
  end

endmodule

FILE: files.f
design/cip_pkg.sv
design/cip_dc.sv
design/cip_row.sv
design/chroma_intra_predictor_8x8_unit.sv
sim/tb_top.sv
